// ===== design/twt_pkg.sv =====
package twt_pkg;

  // Fixed field widths
  localparam int unsigned CmdW    = 2;
  localparam int unsigned GroupW  = 4;
  localparam int unsigned CookieW = 32;
  localparam int unsigned TidW    = 10;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgW    = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_LOOKUP   = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_GROUP = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // take input item, read its group row
    logic commit;  // write back a changed row and load the result register
  } dp_ctrl_t;

endpackage

// ===== design/tagged_waiter_table.sv =====
// Waiter table: NUM_GROUPS groups of SLOTS_PER_GROUP slots, each slot a 32-bit cookie,
// a 10-bit thread id and a valid mark. Commands register, release or look up a waiter
// and each gives exactly one status/found_thread result. An item first does the registered read
// of the group's row from the row memory, then compares all slots of the row in parallel
// and writes the row back; a new item is taken the cycle after the write-back, so the block
// takes no new item until the last one is through. A stalled result holds the block in its
// compare cycle. Reset is immediate: per-row written flags make untouched rows read as
// cookie zero, invalid. The user must write groups_in_use over the cfg port only while the
// block is idle; the block does not enforce this.
module tagged_waiter_table #(
  parameter int unsigned NUM_GROUPS      = 16,
  parameter int unsigned SLOTS_PER_GROUP = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [twt_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [twt_pkg::CmdW-1:0]           cmd_i,
  input  logic [twt_pkg::GroupW-1:0]         group_i,
  input  logic signed [twt_pkg::CookieW-1:0] cookie_i,
  input  logic [twt_pkg::TidW-1:0]           thread_id_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [twt_pkg::StatusW-1:0]        status_o,
  output logic [twt_pkg::TidW-1:0]           found_thread_o
);
  import twt_pkg::*;

  dp_ctrl_t ctrl;

  // Register writes always complete
  assign cfg_ready_o = 1'b1;

  twt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  twt_datapath #(
    .NUM_GROUPS      (NUM_GROUPS),
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .cmd_i          (cmd_i),
    .group_i        (group_i),
    .cookie_i       (cookie_i),
    .thread_id_i    (thread_id_i),
    .status_o       (status_o),
    .found_thread_o (found_thread_o)
  );

endmodule

// ===== design/twt_ctrl.sv =====
module twt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output twt_pkg::dp_ctrl_t ctrl_o
);
  import twt_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  // Output register frees up when empty or its result transfers this cycle
  assign out_free      = !out_valid_q || !out_stall_i;
  assign in_stall_o    = (state_q != S_IDLE);
  assign ctrl_o.load   = (state_q == S_IDLE) && in_valid_i;
  assign ctrl_o.commit = (state_q == S_EXEC) && out_free;
  assign out_valid_o   = out_valid_q;

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (out_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== design/twt_datapath.sv =====
module twt_datapath #(
  parameter int unsigned NUM_GROUPS      = 16,
  parameter int unsigned SLOTS_PER_GROUP = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  twt_pkg::dp_ctrl_t             ctrl_i,
  input  logic                          cfg_we_i,
  input  logic [twt_pkg::CfgW-1:0]      cfg_data_i,
  input  logic [twt_pkg::CmdW-1:0]      cmd_i,
  input  logic [twt_pkg::GroupW-1:0]    group_i,
  input  logic signed [twt_pkg::CookieW-1:0] cookie_i,
  input  logic [twt_pkg::TidW-1:0]      thread_id_i,
  output logic [twt_pkg::StatusW-1:0]   status_o,
  output logic [twt_pkg::TidW-1:0]      found_thread_o
);
  import twt_pkg::*;

  localparam int unsigned RowW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int unsigned S    = SLOTS_PER_GROUP;

  typedef logic [S-1:0][CookieW-1:0] cookie_row_t;
  typedef logic [S-1:0][TidW-1:0]    thread_row_t;
  typedef logic [S-1:0]              slot_vec_t;

  // Row memories, one row per group
  cookie_row_t mem_cookie [NUM_GROUPS];
  slot_vec_t   mem_valid  [NUM_GROUPS];
  thread_row_t mem_thread [NUM_GROUPS];

  logic [NUM_GROUPS-1:0] row_init_q;
  logic [CfgW-1:0]       groups_q;

  // Held item and row read data
  cmd_e              cmd_q;
  logic [GroupW-1:0] group_q;
  logic [CookieW-1:0] key_q;
  logic [TidW-1:0]   tid_q;
  cookie_row_t       rd_cookie_q;
  slot_vec_t         rd_valid_q;
  thread_row_t       rd_thread_q;
  logic              rd_init_q;

  // Result register
  status_e           status_q;
  logic [TidW-1:0]   found_q;

  logic [RowW-1:0]   rd_idx;
  logic [RowW-1:0]   wr_idx;
  logic              rd_in_range;

  cookie_row_t       row_cookie;
  slot_vec_t         row_valid;
  slot_vec_t         match;
  slot_vec_t         match_1h;
  slot_vec_t         free;
  slot_vec_t         free_1h;
  logic              dup;
  logic              bad_group;
  logic              hit_valid;
  logic [TidW-1:0]   hit_thread;

  cookie_row_t       new_cookie;
  slot_vec_t         new_valid;
  thread_row_t       new_thread;
  logic              wr_need;
  logic              wr_en;
  status_e           status_d;
  logic [TidW-1:0]   found_d;

  assign rd_idx      = RowW'(group_i);
  assign wr_idx      = RowW'(group_q);
  assign rd_in_range = (32'(group_i) < 32'(NUM_GROUPS));

  // Rows never written read as cookie zero, all invalid
  assign row_cookie = rd_init_q ? rd_cookie_q : '0;
  assign row_valid  = rd_init_q ? rd_valid_q : '0;

  // Parallel slot compare and first-slot picks
  always_comb begin
    for (int s = 0; s < S; s++) begin
      match[s] = (row_cookie[s] == key_q);
    end
  end

  assign free      = ~row_valid;
  assign free_1h   = free & (~free + S'(1));
  assign match_1h  = match & (~match + S'(1));
  assign dup       = |(match & row_valid);
  assign hit_valid = |(match_1h & row_valid);

  always_comb begin
    hit_thread = '0;
    for (int s = 0; s < S; s++) begin
      hit_thread = hit_thread | (rd_thread_q[s] & {TidW{match_1h[s]}});
    end
  end

  assign bad_group = ({1'b0, group_q} >= groups_q) || (32'(group_q) >= 32'(NUM_GROUPS));

  // Command evaluation and row update
  always_comb begin
    status_d   = ST_OK;
    found_d    = '0;
    wr_need    = 1'b0;
    new_cookie = row_cookie;
    new_valid  = row_valid;
    new_thread = rd_thread_q;
    for (int s = 0; s < S; s++) begin
      if (free_1h[s]) begin
        new_cookie[s] = key_q;
        new_thread[s] = tid_q;
      end
    end
    case (cmd_q)
      CMD_NOP: begin
        status_d = ST_OK;
      end
      CMD_REGISTER: begin
        if (bad_group) begin
          status_d = ST_BAD_GROUP;
        end else if (dup) begin
          status_d = ST_DUPLICATE;
        end else if (free == '0) begin
          status_d = ST_FULL;
        end else begin
          new_valid = row_valid | free_1h;
          wr_need   = 1'b1;
        end
      end
      CMD_RELEASE, CMD_LOOKUP: begin
        new_cookie = row_cookie;
        new_thread = rd_thread_q;
        if (bad_group) begin
          status_d = ST_BAD_GROUP;
        end else if (match == '0) begin
          status_d = ST_NOT_FOUND;
        end else if (!hit_valid) begin
          status_d = ST_CLEARED;
        end else if (cmd_q == CMD_RELEASE) begin
          new_valid = row_valid & ~match_1h;
          wr_need   = 1'b1;
        end else begin
          found_d = hit_thread;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign wr_en = ctrl_i.commit && wr_need;

  // Row memory: write back on commit, registered read on load
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_cookie[wr_idx] <= new_cookie;
      mem_valid[wr_idx]  <= new_valid;
      mem_thread[wr_idx] <= new_thread;
    end
    if (ctrl_i.load) begin
      rd_cookie_q <= mem_cookie[rd_idx];
      rd_valid_q  <= mem_valid[rd_idx];
      rd_thread_q <= mem_thread[rd_idx];
      rd_init_q   <= rd_in_range && row_init_q[rd_idx];
      cmd_q       <= cmd_e'(cmd_i);
      group_q     <= group_i;
      key_q       <= cookie_i;
      tid_q       <= thread_id_i;
    end
    if (ctrl_i.commit) begin
      status_q <= status_d;
      found_q  <= found_d;
    end
  end

  // Row written flags and the group count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
      groups_q   <= '0;
    end else begin
      if (wr_en) begin
        row_init_q[wr_idx] <= 1'b1;
      end
      if (cfg_we_i) begin
        groups_q <= cfg_data_i;
      end
    end
  end

  assign status_o       = status_q;
  assign found_thread_o = found_q;

endmodule

// ===== verif/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import twt_pkg::*;

  localparam int unsigned NUM_GROUPS      = 16;
  localparam int unsigned SLOTS_PER_GROUP = 8;
  localparam int unsigned POOL_SIZE       = 12;
  localparam int unsigned STALL_LIMIT     = 5000;
  localparam int unsigned MAX_REPORTS     = 10;

  typedef struct packed {
    status_e             status;
    logic [TidW-1:0]     thread;
  } answer_t;

  // Clock and reset
  logic clk = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk = ~clk;

  // Block inputs, all known from time zero
  logic                      cfg_valid_i = 1'b0;
  logic [CfgW-1:0]           cfg_data_i = '0;
  logic                      in_valid_i = 1'b0;
  logic [CmdW-1:0]           cmd_i = CMD_NOP;
  logic [GroupW-1:0]         group_i = '0;
  logic signed [CookieW-1:0] cookie_i = '0;
  logic [TidW-1:0]           thread_id_i = '0;
  logic                      out_stall_i = 1'b0;

  // Block outputs
  logic                      cfg_ready_o;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic [StatusW-1:0]        status_o;
  logic [TidW-1:0]           found_thread_o;

  tagged_waiter_table #(
    .NUM_GROUPS      (NUM_GROUPS),
    .SLOTS_PER_GROUP (SLOTS_PER_GROUP)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cmd_i          (cmd_i),
    .group_i        (group_i),
    .cookie_i       (cookie_i),
    .thread_id_i    (thread_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .found_thread_o (found_thread_o)
  );

  wire cfg_xfer = cfg_valid_i && cfg_ready_o;
  wire in_xfer  = in_valid_i && !in_stall_o;
  wire out_xfer = out_valid_o && !out_stall_i;

  // Shadow copy of the waiter table
  logic [CookieW-1:0] row_cookie [NUM_GROUPS][SLOTS_PER_GROUP];
  logic               row_live   [NUM_GROUPS][SLOTS_PER_GROUP];
  logic [TidW-1:0]    row_thread [NUM_GROUPS][SLOTS_PER_GROUP];
  logic [CfgW-1:0]    group_count;

  answer_t pending_answers[$];
  int unsigned fail_count = 0;

  // Sender and receiver idle controls
  int unsigned burst_left = 0;
  int unsigned gap_max = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_run_max = 1;
  int unsigned stall_run = 0;

  logic [CookieW-1:0] cookie_pool [POOL_SIZE];

  initial begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
        row_cookie[g][s] = '0;
        row_live[g][s]   = 1'b0;
        row_thread[g][s] = '0;
      end
    end
    group_count = '0;
  end

  // Apply one command to the shadow table and return its answer
  function automatic answer_t predict_waiter_cmd(cmd_e op, logic [GroupW-1:0] g,
                                                 logic [CookieW-1:0] key,
                                                 logic [TidW-1:0] tid);
    answer_t a;
    int free_slot;
    int hit;
    bit dup;
    a.status = ST_OK;
    a.thread = '0;
    free_slot = -1;
    hit = -1;
    dup = 1'b0;
    if (op == CMD_NOP) begin
      // no effect
    end else if (g >= group_count || g >= NUM_GROUPS) begin
      a.status = ST_BAD_GROUP;
    end else if (op == CMD_REGISTER) begin
      for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
        if (!row_live[g][s]) begin
          if (free_slot < 0) free_slot = s;
        end else if (row_cookie[g][s] == key) begin
          dup = 1'b1;
        end
      end
      // duplicate wins over a full row
      if (dup) begin
        a.status = ST_DUPLICATE;
      end else if (free_slot < 0) begin
        a.status = ST_FULL;
      end else begin
        row_cookie[g][free_slot] = key;
        row_thread[g][free_slot] = tid;
        row_live[g][free_slot]   = 1'b1;
      end
    end else begin
      // first cookie match in slot order, live or not
      for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--) begin
        if (row_cookie[g][s] == key) hit = s;
      end
      if (hit < 0) begin
        a.status = ST_NOT_FOUND;
      end else if (!row_live[g][hit]) begin
        a.status = ST_CLEARED;
      end else if (op == CMD_RELEASE) begin
        row_live[g][hit] = 1'b0;
      end else begin
        a.thread = row_thread[g][hit];
      end
    end
    return a;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endfunction

  // Track config and input transfers, check each result transfer
  always @(posedge clk) begin
    answer_t want;
    if (cfg_xfer) group_count = cfg_data_i;
    if (in_xfer) begin
      pending_answers.push_back(predict_waiter_cmd(cmd_e'(cmd_i), group_i, cookie_i,
                                                   thread_id_i));
    end
    if (out_xfer) begin
      if (pending_answers.size() == 0) begin
        note_failure($sformatf("%0t: result with none pending: status %0d thread %0d",
                               $realtime, status_o, found_thread_o));
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status || found_thread_o !== want.thread) begin
          note_failure($sformatf("%0t: status exp %0d got %0d, thread exp %0d got %0d",
                                 $realtime, want.status, status_o, want.thread,
                                 found_thread_o));
        end
      end
    end
  end

  // Receiver stall pattern: runs of random length
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_run = $urandom_range(1, stall_run_max);
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end else begin
      stall_run--;
    end
  end

  // Watchdog on cycles without any transfer
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (cfg_xfer || in_xfer || out_xfer) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Send one item; valid stays high after the transfer unless a gap follows
  task automatic send_op(cmd_e op, logic [GroupW-1:0] g, logic [CookieW-1:0] key,
                         logic [TidW-1:0] tid);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gap_max > 0) gap = $urandom_range(0, gap_max);
    end
    burst_left--;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    group_i     <= g;
    cookie_i    <= key;
    thread_id_i <= tid;
    do @(posedge clk); while (in_stall_o);
  endtask

  // Drain outstanding results, then write groups_in_use
  task automatic write_group_count(logic [CfgW-1:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_idling(int unsigned gaps, int unsigned pct, int unsigned run_max);
    gap_max = gaps;
    stall_pct = pct;
    stall_run_max = run_max;
  endtask

  // Group 0 rejected before any group is allocated, then the unused command and a never-written row
  task automatic test_bad_group_and_nop();
    send_op(CMD_REGISTER, 4'd0, 32'd1, 10'd1);
    send_op(CMD_LOOKUP, 4'd0, 32'd0, 10'd0);
    write_group_count(5'd16);
    send_op(CMD_NOP, 4'd15, 32'hFFFF_FFFF, 10'h3FF);
    // never-written row: cookie zero hits an invalid slot
    send_op(CMD_LOOKUP, 4'd5, 32'd0, 10'd0);
    send_op(CMD_RELEASE, 4'd5, 32'd5, 10'd0);
  endtask

  // Register, duplicate, lookup, double release at the cookie extremes
  task automatic test_waiter_lifecycle();
    send_op(CMD_REGISTER, 4'd15, 32'h8000_0000, 10'h3FF);
    send_op(CMD_REGISTER, 4'd15, 32'h8000_0000, 10'd7);
    send_op(CMD_LOOKUP, 4'd15, 32'h8000_0000, 10'd0);
    send_op(CMD_RELEASE, 4'd15, 32'h8000_0000, 10'd0);
    send_op(CMD_RELEASE, 4'd15, 32'h8000_0000, 10'd0);
    send_op(CMD_REGISTER, 4'd15, 32'h7FFF_FFFF, 10'd0);
    send_op(CMD_LOOKUP, 4'd15, 32'h7FFF_FFFF, 10'd0);
  endtask

  // Fill a row, overflow it, and hit a duplicate on the full row
  task automatic test_full_row();
    for (int s = 0; s < SLOTS_PER_GROUP; s++) begin
      send_op(CMD_REGISTER, 4'd3, 32'd100 + s, 10'(s * 97));
    end
    send_op(CMD_REGISTER, 4'd3, 32'd200, 10'd1);
    send_op(CMD_REGISTER, 4'd3, 32'd103, 10'd2);
  endtask

  // Random commands on a small cookie pool so matches and full rows are common
  task automatic run_random_phase(logic [CfgW-1:0] groups, int unsigned count);
    logic [CookieW-1:0] key;
    logic [GroupW-1:0] g;
    int unsigned pick;
    cmd_e op;
    write_group_count(groups);
    cookie_pool[0] = '0;
    cookie_pool[1] = 32'hFFFF_FFFF;
    cookie_pool[2] = 32'h8000_0000;
    cookie_pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) cookie_pool[i] = $urandom();
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) op = CMD_REGISTER;
      else if (pick < 70) op = CMD_RELEASE;
      else if (pick < 95) op = CMD_LOOKUP;
      else op = CMD_NOP;
      if (groups != 0 && $urandom_range(0, 99) < 85) begin
        g = GroupW'($urandom_range(0, groups - 1));
      end else begin
        g = GroupW'($urandom_range(0, 15));
      end
      if ($urandom_range(0, 99) < 15) key = $urandom();
      else key = cookie_pool[$urandom_range(0, POOL_SIZE - 1)];
      send_op(op, g, key, TidW'($urandom_range(0, 1023)));
    end
  endtask

  task automatic test_random_traffic();
    set_idling(0, 0, 1);
    run_random_phase(5'd16, 350);
    set_idling(3, 30, 4);
    run_random_phase(5'd1, 150);
    set_idling(6, 50, 8);
    run_random_phase(5'd0, 50);
    set_idling(2, 20, 2);
    run_random_phase(5'($urandom_range(2, 15)), 400);
    set_idling(12, 70, 20);
    run_random_phase(5'd7, 300);
    set_idling(1, 10, 3);
    run_random_phase(5'd16, 450);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_bad_group_and_nop();
    test_waiter_lifecycle();
    test_full_row();
    test_random_traffic();

    // drain and let any stray result show up
    in_valid_i <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending_answers.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
